FILE: rtl/bkfi_pkg.sv
// ----------------------------------------------------------------------------
// bkfi_pkg
// Types, constants and constant point tables of the bend K-factor interpolator.
// ----------------------------------------------------------------------------
package bkfi_pkg;

  localparam int RATIO_W   = 24;
  localparam int KF_W      = 16;
  localparam int LEN_W     = 20;
  localparam int MODE_W    = 2;
  localparam int MAT_W     = 3;
  localparam int SRC_W     = 2;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  localparam int DIN_POINTS      = 9;
  localparam int MATERIAL_COUNT  = 4;
  localparam int MATERIAL_POINTS = 5;
  localparam int MAX_POINTS = (DIN_POINTS > MATERIAL_POINTS) ? DIN_POINTS : MATERIAL_POINTS;

  localparam int PT_W  = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DP_W  = $clog2(DIN_POINTS);
  localparam int MP_W  = $clog2(MATERIAL_POINTS);
  localparam int MC_W  = $clog2(MATERIAL_COUNT);
  localparam int TSEL_W = $clog2(MATERIAL_COUNT + 1);

  typedef logic [RATIO_W-1:0] ratio_t;
  typedef logic [KF_W-1:0]    kf_t;
  typedef logic [TSEL_W-1:0]  tsel_t;
  typedef logic [PT_W-1:0]    pt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_DIN_RATIO  = 2'd0,
    MODE_DIN_DIVIDE = 2'd1,
    MODE_MATERIAL   = 2'd2
  } mode_t;

  typedef enum logic [SRC_W-1:0] {
    SRC_MATERIAL = 2'd0,
    SRC_DIN      = 2'd1,
    SRC_DEFAULT  = 2'd2
  } src_t;

  // Table select: material codes select their own table, this one the DIN table.
  localparam tsel_t TSEL_DIN = tsel_t'(MATERIAL_COUNT);

  localparam kf_t    KF_DEFAULT = 16'd28836;
  localparam ratio_t RATIO_MAX  = 24'hFFFFFF;

  localparam ratio_t DIN_X [DIN_POINTS] = '{
    24'd6554, 24'd16384, 24'd32768, 24'd65536, 24'd131072,
    24'd196608, 24'd262144, 24'd327680, 24'd655360
  };
  localparam kf_t DIN_K [DIN_POINTS] = '{
    16'd20972, 16'd22938, 16'd24904, 16'd27525, 16'd29164,
    16'd30802, 16'd31130, 16'd31457, 16'd32768
  };

  localparam ratio_t MAT_X [MATERIAL_COUNT][MATERIAL_POINTS] = '{
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360},
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360},
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360},
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360}
  };
  localparam kf_t MAT_K [MATERIAL_COUNT][MATERIAL_POINTS] = '{
    '{16'd21627, 16'd24904, 16'd28836, 16'd30147, 16'd32768},
    '{16'd21627, 16'd26214, 16'd29491, 16'd31457, 16'd32768},
    '{16'd21627, 16'd24904, 16'd26214, 16'd27525, 16'd32768},
    '{16'd22938, 16'd26870, 16'd29491, 16'd30802, 16'd32768}
  };

  // Sideband carried through the ratio divider.
  typedef struct packed {
    logic   use_div;
    logic   sat;
    logic   dflt;
    tsel_t  tsel;
    ratio_t ratio;
    src_t   src;
  } front_t;

  // Sideband carried through the interpolation divider.
  typedef struct packed {
    kf_t  k0;
    logic neg;
    logic direct;
    kf_t  dval;
    src_t src;
  } back_t;

  typedef struct packed {
    src_t source;
    kf_t  k_factor;
  } result_t;

  // Index of the last point of the selected table.
  function automatic pt_t pt_last(input tsel_t sel);
    pt_t last;
    if (sel < TSEL_DIN) begin
      last = pt_t'(MATERIAL_POINTS - 1);
    end else begin
      last = pt_t'(DIN_POINTS - 1);
    end
    return last;
  endfunction

  // Ratio of a point. Entries past the end read as all ones so that they
  // never count as lying below a ratio.
  function automatic ratio_t pt_x(input tsel_t sel, input pt_t i);
    ratio_t x;
    x = '1;
    if (sel < TSEL_DIN) begin
      if (i < pt_t'(MATERIAL_POINTS)) begin
        x = MAT_X[sel[MC_W-1:0]][i[MP_W-1:0]];
      end
    end else if (i < pt_t'(DIN_POINTS)) begin
      x = DIN_X[i[DP_W-1:0]];
    end
    return x;
  endfunction

  function automatic kf_t pt_k(input tsel_t sel, input pt_t i);
    kf_t k;
    k = '0;
    if (sel < TSEL_DIN) begin
      if (i < pt_t'(MATERIAL_POINTS)) begin
        k = MAT_K[sel[MC_W-1:0]][i[MP_W-1:0]];
      end
    end else if (i < pt_t'(DIN_POINTS)) begin
      k = DIN_K[i[DP_W-1:0]];
    end
    return k;
  endfunction

endpackage

FILE: rtl/bkfi_div_pipe.sv
// ----------------------------------------------------------------------------
// bkfi_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
// The numerator's upper DW bits must be below the divisor, so the quotient
// fits in QW bits. A sideband word and a valid bit travel with each item.
module bkfi_div_pipe #(
  parameter int QW = 16,
  parameter int DW = 24,
  parameter int SW = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [DW+QW-1:0]   in_num,
  input  logic [DW-1:0]      in_den,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quot,
  output logic [SW-1:0]      out_side
);

  logic          valid_q [QW];
  logic [DW-1:0] rem_q   [QW];
  logic [QW-1:0] low_q   [QW];
  logic [QW-1:0] quot_q  [QW];
  logic [DW-1:0] den_q   [QW];
  logic [SW-1:0] side_q  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic          valid_in;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quot_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          fits;

    if (i == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = in_num[DW+QW-1:QW];
      assign low_in   = in_num[QW-1:0];
      assign quot_in  = '0;
      assign den_in   = in_den;
      assign side_in  = in_side;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign rem_in   = rem_q[i-1];
      assign low_in   = low_q[i-1];
      assign quot_in  = quot_q[i-1];
      assign den_in   = den_q[i-1];
      assign side_in  = side_q[i-1];
    end

    assign trial = {rem_in, low_in[QW-1]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= fits ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        low_q[i]  <= low_in << 1;
        quot_q[i] <= (quot_in << 1) | QW'(fits);
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign out_valid = valid_q[QW-1];
  assign out_quot  = quot_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

FILE: rtl/bend_k_factor_interpolator.sv
// ----------------------------------------------------------------------------
// bend_k_factor_interpolator
// Sheet-metal bend K-factor by piecewise linear interpolation in fixed tables.
// ----------------------------------------------------------------------------
// Each input item on s_axis carries a mode, a material code, a Q8.16 ratio and
// a radius and thickness in micrometres. Each yields exactly one result item
// on m_axis: a Q0.16 K-factor and the source it came from (material table,
// DIN table or the default for zero thickness in divide mode).
// The block is a pipeline from input to output: one input stage, a 24-stage
// ratio divider for radius over thickness, table search, point fetch and
// multiply stages, a 16-stage divider for the interpolation quotient and the
// output register. One item is taken every cycle while the skid register is
// empty; the two dividers, one bit per stage, set the latency.
// When the receiver stalls, the output register holds its item and one more
// item lands in a skid register; s_axis_tready then falls and the whole
// pipeline freezes until the skid register drains. Nothing is dropped or
// repeated. Reset (rst, synchronous) empties the pipeline and the output.
module bend_k_factor_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: mode[1:0], material[4:2], ratio[28:5], radius[48:29],
  // thickness[68:49], zero fill[71:69].
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: k_factor[15:0], source[17:16], zero fill[23:18].
  output logic [23:0] m_axis_tdata
);

  localparam int NUM1_W = bkfi_pkg::LEN_W + bkfi_pkg::RATIO_W;
  localparam int NUM2_W = bkfi_pkg::RATIO_W + bkfi_pkg::KF_W;

  logic en;

  // Input fields.
  logic [bkfi_pkg::MODE_W-1:0] in_mode;
  logic [bkfi_pkg::MAT_W-1:0]  in_material;
  bkfi_pkg::ratio_t            in_ratio;
  logic [bkfi_pkg::LEN_W-1:0]  in_radius;
  logic [bkfi_pkg::LEN_W-1:0]  in_thickness;

  assign in_mode      = s_axis_tdata[1:0];
  assign in_material  = s_axis_tdata[4:2];
  assign in_ratio     = s_axis_tdata[28:5];
  assign in_radius    = s_axis_tdata[48:29];
  assign in_thickness = s_axis_tdata[68:49];

  // Stage 0: decode, dividend with rounding offset, saturation check.
  logic                 is_div;
  logic                 use_mat;
  logic [36:0]          num_full;
  logic                 num_sat;
  bkfi_pkg::front_t     front_in;

  assign is_div   = (in_mode == bkfi_pkg::MODE_DIN_DIVIDE);
  assign use_mat  = (in_mode == bkfi_pkg::MODE_MATERIAL) &&
                    ({1'b0, in_material} < 4'(bkfi_pkg::MATERIAL_COUNT));
  assign num_full = {1'b0, in_radius, 16'b0} + 37'(in_thickness >> 1);
  assign num_sat  = ({7'b0, num_full} >= {in_thickness, 24'b0});

  always_comb begin
    front_in.use_div = is_div;
    front_in.sat     = num_sat;
    front_in.dflt    = is_div && (in_thickness == '0);
    front_in.tsel    = use_mat ? bkfi_pkg::tsel_t'(in_material) : bkfi_pkg::TSEL_DIN;
    front_in.ratio   = in_ratio;
    if (is_div && (in_thickness == '0)) begin
      front_in.src = bkfi_pkg::SRC_DEFAULT;
    end else if (use_mat) begin
      front_in.src = bkfi_pkg::SRC_MATERIAL;
    end else begin
      front_in.src = bkfi_pkg::SRC_DIN;
    end
  end

  logic                        s0_valid;
  logic [NUM1_W-1:0]           s0_num;
  logic [bkfi_pkg::LEN_W-1:0]  s0_den;
  bkfi_pkg::front_t            s0_front;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_num   <= {7'b0, num_full};
      s0_den   <= in_thickness;
      s0_front <= front_in;
    end
  end

  // Radius over thickness, 24 quotient bits.
  logic                          d1_valid;
  bkfi_pkg::ratio_t              d1_quot;
  logic [$bits(bkfi_pkg::front_t)-1:0] d1_side;
  bkfi_pkg::front_t              d1_front;

  bkfi_div_pipe #(
    .QW (bkfi_pkg::RATIO_W),
    .DW (bkfi_pkg::LEN_W),
    .SW ($bits(bkfi_pkg::front_t))
  ) u_div_ratio (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s0_valid),
    .in_num    (s0_num),
    .in_den    (s0_den),
    .in_side   (s0_front),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_side  (d1_side)
  );

  assign d1_front = d1_side;

  // Segment search: count the points that lie below the ratio.
  bkfi_pkg::ratio_t               r_sel;
  logic [bkfi_pkg::MAX_POINTS-1:0] below;
  logic [bkfi_pkg::CNT_W-1:0]     below_cnt;
  logic                           r_lo;
  logic                           r_hi;

  always_comb begin
    if (!d1_front.use_div) begin
      r_sel = d1_front.ratio;
    end else if (d1_front.sat) begin
      r_sel = bkfi_pkg::RATIO_MAX;
    end else begin
      r_sel = d1_quot;
    end
    for (int j = 0; j < bkfi_pkg::MAX_POINTS; j++) begin
      below[j] = (bkfi_pkg::pt_x(d1_front.tsel, bkfi_pkg::pt_t'(j)) < r_sel);
    end
  end

  assign below_cnt = bkfi_pkg::CNT_W'($countones(below));
  assign r_lo = (r_sel <= bkfi_pkg::pt_x(d1_front.tsel, '0));
  assign r_hi = (r_sel >= bkfi_pkg::pt_x(d1_front.tsel, bkfi_pkg::pt_last(d1_front.tsel)));

  logic                 s1_valid;
  bkfi_pkg::ratio_t     s1_r;
  bkfi_pkg::tsel_t      s1_tsel;
  logic                 s1_lo;
  logic                 s1_hi;
  logic                 s1_dflt;
  bkfi_pkg::pt_t        s1_seg;
  bkfi_pkg::src_t       s1_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r    <= r_sel;
      s1_tsel <= d1_front.tsel;
      s1_lo   <= r_lo;
      s1_hi   <= r_hi;
      s1_dflt <= d1_front.dflt;
      s1_seg  <= bkfi_pkg::pt_t'(below_cnt - 1'b1);
      s1_src  <= d1_front.src;
    end
  end

  // Point fetch and differences.
  bkfi_pkg::ratio_t x0;
  bkfi_pkg::ratio_t x1;
  bkfi_pkg::kf_t    k0;
  bkfi_pkg::kf_t    k1;
  bkfi_pkg::ratio_t dx;
  logic             direct;
  bkfi_pkg::kf_t    dval;

  assign x0 = bkfi_pkg::pt_x(s1_tsel, s1_seg);
  assign x1 = bkfi_pkg::pt_x(s1_tsel, s1_seg + 1'b1);
  assign k0 = bkfi_pkg::pt_k(s1_tsel, s1_seg);
  assign k1 = bkfi_pkg::pt_k(s1_tsel, s1_seg + 1'b1);
  assign dx = x1 - x0;
  assign direct = s1_dflt || s1_lo || s1_hi || (dx == '0);

  always_comb begin
    if (s1_dflt) begin
      dval = bkfi_pkg::KF_DEFAULT;
    end else if (s1_lo) begin
      dval = bkfi_pkg::pt_k(s1_tsel, '0);
    end else if (s1_hi) begin
      dval = bkfi_pkg::pt_k(s1_tsel, bkfi_pkg::pt_last(s1_tsel));
    end else begin
      dval = k0;
    end
  end

  logic                 s2_valid;
  bkfi_pkg::ratio_t     s2_dr;
  bkfi_pkg::ratio_t     s2_dx;
  bkfi_pkg::kf_t        s2_dk;
  bkfi_pkg::back_t      s2_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dr          <= s1_r - x0;
      s2_dx          <= dx;
      s2_dk          <= (k1 < k0) ? (k0 - k1) : (k1 - k0);
      s2_back.k0     <= k0;
      s2_back.neg    <= (k1 < k0);
      s2_back.direct <= direct;
      s2_back.dval   <= dval;
      s2_back.src    <= s1_src;
    end
  end

  // Product of ratio offset and K step.
  logic                 s3_valid;
  logic [NUM2_W-1:0]    s3_prod;
  bkfi_pkg::ratio_t     s3_dx;
  bkfi_pkg::back_t      s3_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_prod <= NUM2_W'(s2_dr) * NUM2_W'(s2_dk);
      s3_dx   <= s2_dx;
      s3_back <= s2_back;
    end
  end

  // Rounded quotient: (product + dx/2) / dx, never above the K step.
  logic                                d2_valid;
  bkfi_pkg::kf_t                       d2_quot;
  logic [$bits(bkfi_pkg::back_t)-1:0]  d2_side;
  bkfi_pkg::back_t                     d2_back;

  bkfi_div_pipe #(
    .QW (bkfi_pkg::KF_W),
    .DW (bkfi_pkg::RATIO_W),
    .SW ($bits(bkfi_pkg::back_t))
  ) u_div_interp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .in_num    (s3_prod + NUM2_W'(s3_dx >> 1)),
    .in_den    (s3_dx),
    .in_side   (s3_back),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_side  (d2_side)
  );

  assign d2_back = d2_side;

  bkfi_pkg::result_t pipe_result;

  always_comb begin
    pipe_result.source = d2_back.src;
    if (d2_back.direct) begin
      pipe_result.k_factor = d2_back.dval;
    end else if (d2_back.neg) begin
      pipe_result.k_factor = d2_back.k0 - d2_quot;
    end else begin
      pipe_result.k_factor = d2_back.k0 + d2_quot;
    end
  end

  // Output register with one skid entry; the pipeline runs while the skid
  // entry is empty.
  logic              out_valid;
  bkfi_pkg::result_t out_data;
  logic              skid_valid;
  bkfi_pkg::result_t skid_data;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      out_valid  <= skid_valid || d2_valid;
      skid_valid <= 1'b0;
    end else if (d2_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_data <= skid_valid ? skid_data : pipe_result;
    end else if (!skid_valid) begin
      skid_data <= pipe_result;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_data};

  // The skid entry is only ever filled behind a waiting output item.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds an item while the output is empty");

  // Reset empties the output side.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !skid_valid)
    else $error("output side not empty after reset");

  // An item between two points has its offset inside the segment.
  a_segment_span: assert property (@(posedge clk) disable iff (rst)
    en && s1_valid && !s1_lo && !s1_hi && !s1_dflt |=> s2_dr <= s2_dx)
    else $error("ratio offset exceeds the selected segment");

  // The default source always carries the default K-factor.
  a_default_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.source == bkfi_pkg::SRC_DEFAULT)
      |-> out_data.k_factor == bkfi_pkg::KF_DEFAULT)
    else $error("default source with a K-factor other than the default");

endmodule

FILE: tb/bend_k_factor_interpolator_tb.sv
// ----------------------------------------------------------------------------
// bend_k_factor_interpolator_tb
// Self-checking bench for the bend K-factor interpolator.
// ----------------------------------------------------------------------------
// A table of directed queries covers the ends of the ratio range, some DIN
// table points, every mode and material, zero thickness and the saturating divide.
// About 1750 random queries follow. Each result item is compared with a
// K-factor given in the table or worked out by a local copy of the point
// tables and the rounding interpolation. Both stream sides idle and stall at
// random, with calm stretches in between.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bend_k_factor_interpolator_tb;

  localparam logic [bkfi_pkg::MODE_W-1:0] MD_RATIO   = bkfi_pkg::MODE_DIN_RATIO;
  localparam logic [bkfi_pkg::MODE_W-1:0] MD_DIVIDE  = bkfi_pkg::MODE_DIN_DIVIDE;
  localparam logic [bkfi_pkg::MODE_W-1:0] MD_MAT     = bkfi_pkg::MODE_MATERIAL;
  localparam logic [bkfi_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam bkfi_pkg::src_t SR_MAT  = bkfi_pkg::SRC_MATERIAL;
  localparam bkfi_pkg::src_t SR_DIN  = bkfi_pkg::SRC_DIN;
  localparam bkfi_pkg::src_t SR_DFLT = bkfi_pkg::SRC_DEFAULT;
  localparam int TAB_DIN     = 4;
  localparam int RAND_ITEMS  = 1750;
  localparam int DRAIN_TICKS = 60;

  typedef struct packed {
    logic [15:0]    k;
    bkfi_pkg::src_t src;
  } k_result_t;

  typedef struct packed {
    logic [1:0]     mode;
    logic [2:0]     material;
    logic [23:0]    ratio;
    logic [19:0]    radius;
    logic [19:0]    thickness;
    logic           typed;
    logic [15:0]    k;
    bkfi_pkg::src_t src;
  } query_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  k_result_t   k_expected_q [$];
  int          err_count = 0;
  int          rx_stall = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  // Point tables, Q8.16 ratio and Q0.16 K: rows 0..3 materials, row 4 DIN.
  logic [23:0] pt_ratio [0:4][0:8] = '{
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360,
      24'd0, 24'd0, 24'd0, 24'd0},
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360,
      24'd0, 24'd0, 24'd0, 24'd0},
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360,
      24'd0, 24'd0, 24'd0, 24'd0},
    '{24'd16384, 24'd65536, 24'd196608, 24'd327680, 24'd655360,
      24'd0, 24'd0, 24'd0, 24'd0},
    '{24'd6554, 24'd16384, 24'd32768, 24'd65536, 24'd131072,
      24'd196608, 24'd262144, 24'd327680, 24'd655360}
  };
  logic [15:0] pt_k [0:4][0:8] = '{
    '{16'd21627, 16'd24904, 16'd28836, 16'd30147, 16'd32768,
      16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd21627, 16'd26214, 16'd29491, 16'd31457, 16'd32768,
      16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd21627, 16'd24904, 16'd26214, 16'd27525, 16'd32768,
      16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd22938, 16'd26870, 16'd29491, 16'd30802, 16'd32768,
      16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd20972, 16'd22938, 16'd24904, 16'd27525, 16'd29164,
      16'd30802, 16'd31130, 16'd31457, 16'd32768}
  };

  query_row_t directed_rows [0:24] = '{
    '{MD_RATIO,   3'd0, 24'd0,      20'd0,     20'd0,     1'b1, 16'd20972, SR_DIN},
    '{MD_RATIO,   3'd7, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, 16'd32768, SR_DIN},
    '{MD_RATIO,   3'd0, 24'd6554,   20'd0,     20'd0,     1'b1, 16'd20972, SR_DIN},
    '{MD_RATIO,   3'd0, 24'd655360, 20'd0,     20'd0,     1'b1, 16'd32768, SR_DIN},
    '{MD_RATIO,   3'd0, 24'd100000, 20'd0,     20'd0,     1'b0, 16'd0,     SR_DIN},
    '{MD_DIVIDE,  3'd5, 24'hFFFFFF, 20'hFFFFF, 20'd0,     1'b1, 16'd28836, SR_DFLT},
    '{MD_DIVIDE,  3'd0, 24'd0,      20'd0,     20'd0,     1'b1, 16'd28836, SR_DFLT},
    '{MD_DIVIDE,  3'd0, 24'd0,      20'hFFFFF, 20'd1,     1'b1, 16'd32768, SR_DIN},
    '{MD_DIVIDE,  3'd0, 24'd0,      20'd0,     20'hFFFFF, 1'b1, 16'd20972, SR_DIN},
    '{MD_DIVIDE,  3'd0, 24'd0,      20'd3000,  20'd1500,  1'b0, 16'd0,     SR_DIN},
    '{MD_DIVIDE,  3'd0, 24'd0,      20'd1,     20'd3,     1'b0, 16'd0,     SR_DIN},
    '{MD_MAT,     3'd0, 24'd0,      20'd0,     20'd0,     1'b1, 16'd21627, SR_MAT},
    '{MD_MAT,     3'd1, 24'd0,      20'd0,     20'd0,     1'b1, 16'd21627, SR_MAT},
    '{MD_MAT,     3'd2, 24'd0,      20'd0,     20'd0,     1'b1, 16'd21627, SR_MAT},
    '{MD_MAT,     3'd3, 24'd0,      20'd0,     20'd0,     1'b1, 16'd22938, SR_MAT},
    '{MD_MAT,     3'd0, 24'hFFFFFF, 20'd0,     20'd0,     1'b1, 16'd32768, SR_MAT},
    '{MD_MAT,     3'd1, 24'hFFFFFF, 20'd0,     20'd0,     1'b1, 16'd32768, SR_MAT},
    '{MD_MAT,     3'd2, 24'hFFFFFF, 20'd0,     20'd0,     1'b1, 16'd32768, SR_MAT},
    '{MD_MAT,     3'd3, 24'hFFFFFF, 20'd0,     20'd0,     1'b1, 16'd32768, SR_MAT},
    '{MD_MAT,     3'd4, 24'd0,      20'd0,     20'd0,     1'b1, 16'd20972, SR_DIN},
    '{MD_MAT,     3'd7, 24'd200000, 20'd0,     20'd0,     1'b0, 16'd0,     SR_DIN},
    '{MODE_SPARE, 3'd2, 24'd0,      20'd0,     20'd0,     1'b1, 16'd20972, SR_DIN},
    '{MODE_SPARE, 3'd1, 24'd300000, 20'd0,     20'd0,     1'b0, 16'd0,     SR_DIN},
    '{MD_MAT,     3'd2, 24'd100000, 20'd0,     20'd0,     1'b0, 16'd0,     SR_DIN},
    '{MD_RATIO,   3'd7, 24'd65536,  20'hFFFFF, 20'hFFFFF, 1'b1, 16'd27525, SR_DIN}
  };

  bend_k_factor_interpolator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2000000;
    $display("[bend_k_factor_interpolator] ERROR");
    $finish;
  end

  // Linear interpolation in one point table, clamped at both ends, with the
  // quotient rounded to nearest and halves away from zero.
  function automatic logic [15:0] lerp_table(input int t, input logic [23:0] r);
    int              n;
    bit              found;
    longint unsigned dx;
    longint unsigned dr;
    longint unsigned q;
    longint unsigned k0;
    longint unsigned k1;
    logic [15:0]     res;
    n = (t == TAB_DIN) ? bkfi_pkg::DIN_POINTS : bkfi_pkg::MATERIAL_POINTS;
    found = 1'b0;
    res = pt_k[t][n-1];
    if (r <= pt_ratio[t][0]) begin
      res = pt_k[t][0];
    end else if (r < pt_ratio[t][n-1]) begin
      for (int i = 0; i + 1 < n; i++) begin
        if (!found && r <= pt_ratio[t][i+1]) begin
          found = 1'b1;
          dx = pt_ratio[t][i+1] - pt_ratio[t][i];
          dr = r - pt_ratio[t][i];
          k0 = pt_k[t][i];
          k1 = pt_k[t][i+1];
          if (dx == 0) begin
            res = k0[15:0];
          end else if (k1 >= k0) begin
            q = (dr * (k1 - k0) + dx / 2) / dx;
            res = 16'(k0 + q);
          end else begin
            q = (dr * (k0 - k1) + dx / 2) / dx;
            res = 16'(k0 - q);
          end
        end
      end
    end
    return res;
  endfunction

  function automatic k_result_t predict_k_factor(input logic [71:0] data);
    logic [1:0]      mode;
    logic [2:0]      material;
    logic [23:0]     ratio;
    longint unsigned radius;
    longint unsigned thickness;
    longint unsigned q;
    k_result_t       res;
    mode      = data[1:0];
    material  = data[4:2];
    ratio     = data[28:5];
    radius    = data[48:29];
    thickness = data[68:49];
    if (mode == bkfi_pkg::MODE_DIN_DIVIDE) begin
      if (thickness == 0) begin
        res.k   = bkfi_pkg::KF_DEFAULT;
        res.src = bkfi_pkg::SRC_DEFAULT;
      end else begin
        q = ((radius << 16) + thickness / 2) / thickness;
        if (q > 64'hFFFFFF) begin
          q = 64'hFFFFFF;
        end
        res.k   = lerp_table(TAB_DIN, q[23:0]);
        res.src = bkfi_pkg::SRC_DIN;
      end
    end else if (mode == bkfi_pkg::MODE_MATERIAL && material < bkfi_pkg::MATERIAL_COUNT) begin
      res.k   = lerp_table(int'(material), ratio);
      res.src = bkfi_pkg::SRC_MATERIAL;
    end else begin
      res.k   = lerp_table(TAB_DIN, ratio);
      res.src = bkfi_pkg::SRC_DIN;
    end
    return res;
  endfunction

  // Ratio draw: mostly inside the tables, some right at the points, some
  // anywhere in the 24-bit range.
  function automatic logic [23:0] draw_ratio();
    logic [23:0] r;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: r = 24'($urandom_range(0, 720000));
      5, 6:          r = pt_ratio[TAB_DIN][$urandom_range(0, 8)] + 24'($urandom_range(0, 6)) - 24'd3;
      7:             r = 24'($urandom);
      8:             r = 24'($urandom_range(0, 20000));
      default:       r = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic send_query(input logic [71:0] data, input k_result_t exp);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    do @(posedge clk); while (!s_axis_tready);
    k_expected_q = {k_expected_q, exp};
  endtask

  // Result side: checks every accepted item and draws a stall for the next.
  always @(posedge clk) begin
    k_result_t exp;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (k_expected_q.size() == 0) begin
          report_mismatch($sformatf("result item with nothing expected, tdata %h",
                                    m_axis_tdata));
        end else begin
          exp = k_expected_q.pop_front();
          if (m_axis_tdata[15:0] !== exp.k) begin
            report_mismatch($sformatf("k_factor %0d, expected %0d",
                                      m_axis_tdata[15:0], exp.k));
          end
          if (m_axis_tdata[17:16] !== exp.src) begin
            report_mismatch($sformatf("source %0d, expected %0d",
                                      m_axis_tdata[17:16], exp.src));
          end
        end
        rx_stall = rx_calm ? 0 : $urandom_range(0, 12);
      end
      if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
        rx_stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [71:0]     data;
    logic [1:0]      mode;
    logic [19:0]     radius;
    logic [19:0]     thickness;
    longint unsigned span;
    k_result_t       exp;
    wait (!rst);
    @(posedge clk);

    foreach (directed_rows[i]) begin
      data = {3'b000, directed_rows[i].thickness, directed_rows[i].radius,
              directed_rows[i].ratio, directed_rows[i].material, directed_rows[i].mode};
      if (directed_rows[i].typed) begin
        exp.k   = directed_rows[i].k;
        exp.src = directed_rows[i].src;
      end else begin
        exp = predict_k_factor(data);
      end
      send_query(data, exp);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 125 == 0) begin
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:           mode = MD_RATIO;
        6, 7, 8, 9, 10, 11:         mode = MD_DIVIDE;
        12, 13, 14, 15, 16, 17, 18: mode = MD_MAT;
        default:                    mode = MODE_SPARE;
      endcase
      // Radius and thickness mostly give ratios that land inside the DIN
      // table; the rest covers zero thickness and the saturating divide.
      case ($urandom_range(0, 15))
        0:       thickness = 20'd0;
        1, 2, 3: thickness = 20'($urandom);
        default: thickness = 20'($urandom_range(1, 4096));
      endcase
      if ($urandom_range(0, 4) == 0) begin
        radius = 20'($urandom);
      end else begin
        span = longint'(thickness) * 12;
        if (span > 20'hFFFFF) begin
          span = 20'hFFFFF;
        end
        radius = 20'($urandom_range(0, int'(span)));
      end
      data = {3'b000, thickness, radius, draw_ratio(), 3'($urandom_range(0, 7)), mode};
      send_query(data, predict_k_factor(data));
    end
    s_axis_tvalid <= 1'b0;
    rx_calm = 1'b1;

    while (k_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TICKS) @(posedge clk);
    if (err_count == 0) begin
      $display("[bend_k_factor_interpolator] OK");
    end else begin
      $display("[bend_k_factor_interpolator] ERROR");
    end
    $finish;
  end

endmodule

FILE: bend_k_factor_interpolator.f
rtl/bkfi_pkg.sv
rtl/bkfi_div_pipe.sv
rtl/bend_k_factor_interpolator.sv
tb/bend_k_factor_interpolator_tb.sv
